>>> design/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that expr holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed: always");

// Check that cons holds in the cycle after ante, outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next cycle");

`endif

>>> design/kms_pkg.sv
// Shared constants and types of the key matrix scanner.
// No dependencies; imported by every module of the block.
package kms_pkg;

  localparam int ROWS    = 8;
  localparam int COLUMNS = 8;

  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  localparam int LEVEL_W    = 8;
  localparam int DRIVE_W    = 8;
  localparam int CODE_W     = 6;
  localparam int CODE_ROW_W = 3;
  localparam int CODE_COL_W = 3;
  localparam int SCAN_W     = 16;
  localparam int LOCK_W     = 24;

  localparam int CFG_DATA_W  = 24;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_SCAN_PERIOD    = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_LOCKOUT_PERIOD = 1'b1;

  localparam logic [SCAN_W-1:0] SCAN_PERIOD_RESET    = 16'd125;
  localparam logic [LOCK_W-1:0] LOCKOUT_PERIOD_RESET = 24'd250000;

  // Control broadcast to every column lane.
  typedef struct packed {
    logic             accept;
    logic             clear;
    logic [ROW_W-1:0] row;
  } lane_ctrl_t;

endpackage

>>> design/key_matrix_scanner_with_lockout_core.sv
// Key matrix scanner with lockout: top level, counters and config registers.
// Depends on kms_pkg, kms_lane and kms_merge.
// Each request is held in the merge stage before its results enter the output register.
// in_stall holds until the last result loads; the merge emits one result a cycle unless stalled.
// Reset: rst (synchronous) clears row, counters, reported map and pipeline; periods go to
// 125 and 250000.
module key_matrix_scanner_with_lockout_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [kms_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [kms_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [kms_pkg::LEVEL_W-1:0]       column_levels,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [kms_pkg::CODE_W-1:0]        key_code,
  output logic                              key_valid,
  output logic                              last,
  output logic [kms_pkg::DRIVE_W-1:0]       row_drive
);
  import kms_pkg::*;

  // Configuration registers.
  logic [SCAN_W-1:0] scan_period;
  logic [LOCK_W-1:0] lockout_period;

  // Scan and lockout state.
  logic [ROW_W-1:0]  row_index;
  logic [SCAN_W-1:0] scan_count;
  logic [LOCK_W-1:0] lockout_count;

  logic [ROW_W-1:0]   row_index_next;
  logic [SCAN_W-1:0]  scan_inc;
  logic [LOCK_W-1:0]  lock_inc;
  logic [COLUMNS-1:0] fire;
  logic               any_fire;
  logic               accept;
  logic               full;
  lane_ctrl_t         ctrl;

  assign accept   = in_valid && !in_stall;
  assign in_stall = full;
  assign any_fire = |fire;

  assign scan_inc = scan_count + SCAN_W'(1);
  assign lock_inc = lockout_count + LOCK_W'(1);
  assign row_index_next = (row_index == ROW_W'(ROWS - 1)) ? '0 : row_index + ROW_W'(1);

  // Clear the reported map only on a request with no report, once the idle
  // count reaches or passes the lockout period.
  assign ctrl = '{accept: accept,
                  clear:  !any_fire && (lock_inc >= lockout_period),
                  row:    row_index};

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_period    <= SCAN_PERIOD_RESET;
      lockout_period <= LOCKOUT_PERIOD_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SCAN_PERIOD:    scan_period    <= cfg_data[SCAN_W-1:0];
        REG_LOCKOUT_PERIOD: lockout_period <= cfg_data[LOCK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_index     <= '0;
      scan_count    <= '0;
      lockout_count <= '0;
    end else if (accept) begin
      // Restart lockout on any report, else advance and wrap on reaching the period.
      if (any_fire || ctrl.clear) begin
        lockout_count <= '0;
      end else begin
        lockout_count <= lock_inc;
      end
      // Advance the row once the scan count reaches the period; a zero period acts as one.
      if (scan_inc >= scan_period) begin
        scan_count <= '0;
        row_index  <= row_index_next;
      end else begin
        scan_count <= scan_inc;
      end
    end
  end

  // One lane per column, each holding its previous level and reported bits.
  for (genvar c = 0; c < COLUMNS; c++) begin : g_lane
    kms_lane u_lane (
      .clk   (clk),
      .rst   (rst),
      .ctrl  (ctrl),
      .level (column_levels[c]),
      .fire  (fire[c])
    );
  end

  // Serialize the lanes' reports, or one idle result, into the output register.
  kms_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .fire      (fire),
    .row       (row_index),
    .out_stall (out_stall),
    .full      (full),
    .out_valid (out_valid),
    .key_code  (key_code),
    .key_valid (key_valid),
    .last      (last),
    .row_drive (row_drive)
  );

endmodule

>>> design/kms_lane.sv
// One column lane: edge detection and the column's slice of the reported map.
// Depends on kms_pkg.
module kms_lane (
  input  logic                clk,
  input  logic                rst,
  input  kms_pkg::lane_ctrl_t ctrl,
  input  logic                level,
  output logic                fire
);
  import kms_pkg::*;

  logic            prev;
  logic [ROWS-1:0] hit;

  // New report: rising edge on a key of the current row not yet reported.
  assign fire = level & ~prev & ~hit[ctrl.row];

  always_ff @(posedge clk) begin
    if (rst) begin
      prev <= 1'b0;
      hit  <= '0;
    end else if (ctrl.accept) begin
      prev <= level;
      if (ctrl.clear) begin
        hit <= '0;
      end else if (fire) begin
        hit[ctrl.row] <= 1'b1;
      end
    end
  end

endmodule

>>> design/kms_merge.sv
// Merge stage: holds the lanes' report mask of one request and emits one result per
// cycle unless the output stalls, lowest column first, into the output register.
// Depends on kms_pkg.
module kms_merge (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                load,
  input  logic [kms_pkg::COLUMNS-1:0]         fire,
  input  logic [kms_pkg::ROW_W-1:0]           row,
  input  logic                                out_stall,
  output logic                                full,
  output logic                                out_valid,
  output logic [kms_pkg::CODE_W-1:0]          key_code,
  output logic                                key_valid,
  output logic                                last,
  output logic [kms_pkg::DRIVE_W-1:0]         row_drive
);
  import kms_pkg::*;

  logic               batch_valid;
  logic [COLUMNS-1:0] batch_mask;
  logic [ROW_W-1:0]   batch_row;

  logic [COL_W-1:0]   sel;
  logic [COLUMNS-1:0] rest;
  logic               is_last;
  logic               out_load;

  always_comb begin
    sel = '0;
    for (int c = COLUMNS - 1; c >= 0; c--) begin
      if (batch_mask[c]) begin
        sel = COL_W'(c);
      end
    end
  end

  assign rest     = batch_mask & (batch_mask - COLUMNS'(1));
  assign is_last  = (rest == '0);
  assign out_load = batch_valid && (!out_valid || !out_stall);
  assign full     = batch_valid && !(is_last && out_load);

  always_ff @(posedge clk) begin
    if (rst) begin
      batch_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        batch_valid <= 1'b1;
      end else if (out_load && is_last) begin
        batch_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      key_code  <= (batch_mask == '0) ? '0 : {CODE_ROW_W'(batch_row), CODE_COL_W'(sel)};
      key_valid <= (batch_mask != '0);
      last      <= is_last;
      row_drive <= DRIVE_W'(1) << batch_row;
    end
    if (load) begin
      batch_mask <= fire;
      batch_row  <= row;
    end else if (out_load) begin
      batch_mask <= rest;
    end
  end

endmodule

>>> design/kms_checker.sv
// Port-level checks of the key matrix scanner, bound to the top level.
// Depends on kms_pkg and assert_macros.svh.
`include "assert_macros.svh"

module kms_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [kms_pkg::CODE_W-1:0]        key_code,
  input logic                              key_valid,
  input logic                              last,
  input logic [kms_pkg::DRIVE_W-1:0]       row_drive
);
  import kms_pkg::*;

  // An idle result is always the only and final result of its request.
  `ASSERT_ALWAYS(a_idle_last, clk, rst, !out_valid || key_valid || (last && key_code == '0))
  // Exactly one row is driven on every result.
  `ASSERT_ALWAYS(a_drive_onehot, clk, rst, !out_valid || $onehot(row_drive))
  // After a result that is not the last, the output stays valid without a gap.
  `ASSERT_NEXT(a_burst_gapless, clk, rst, out_valid && !last, out_valid)
  // A stalled result holds.
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall,
               out_valid && $stable(key_code) && $stable(key_valid) && $stable(last))

endmodule

bind key_matrix_scanner_with_lockout_core kms_checker u_kms_checker (.*);
